// File: sv/cpn_pkg.sv
// Shared constants and types for the complex phase normalizer.
`default_nettype none
package cpn_pkg;

    localparam int SAMPLE_WIDTH_DEF = 16;
    localparam int FRAC_BITS        = 14;
    localparam int Q_BITS           = FRAC_BITS + 1;       // result magnitude 0..2^FRAC_BITS
    localparam int OUT_WIDTH        = 16;
    localparam int TARGET_SHIFT     = 2 * FRAC_BITS + 2;   // (2q-1)^2 s <= a^2 << 30
    localparam int PREP_STAGES      = 3;
    localparam int PIPE_STAGES      = PREP_STAGES + Q_BITS + 1;

    typedef struct packed {
        logic last;
        logic zero;
        logic neg_im;
        logic neg_re;
    } cpn_flags_t;

endpackage
`default_nettype wire

// File: sv/complex_phase_normalize.sv
// Top level of the complex phase normalizer (unit-magnitude normalization).
//
//  channel | direction | tdata (low bit up)              | tuser          | tlast
//  s_      | in        | real_in[W-1:0], imag_in[W-1:0]  | -              | last_in
//  m_      | out       | real_out[15:0], imag_out[15:0]  | zero_magnitude | last_out
//
// One transaction per clock sustained while m_tready is high (3 front-end stages,
// 15 search stages, one output stage). The search stages carry out a bit-per-stage
// search of round(a * 2^14 / sqrt(re^2 + im^2)).
// aresetn (synchronous, active low) clears only the stage valid bits.
// Each stage loads when it is empty or the stage after it moves, so bubbles
// are squeezed out and a stalled output holds without losing or repeating data.
`default_nettype none
module complex_phase_normalize
    import cpn_pkg::*;
#(
    parameter  int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
    localparam int IN_TDATA_W   = ((2 * SAMPLE_WIDTH + 7) / 8) * 8
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    // input: real_in, imag_in, zero padding
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,
    input  wire logic                   s_tlast,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    // output: real_out, imag_out
    output logic [2*OUT_WIDTH-1:0]      m_tdata,
    // output: zero_magnitude
    output logic [0:0]                  m_tuser,
    output logic                        m_tlast,
    output logic                        m_tvalid,
    input  wire logic                   m_tready
);

    localparam int SW = 2 * SAMPLE_WIDTH;
    localparam int RW = SW + TARGET_SHIFT + 2;

    // per-stage occupancy and load enables
    logic [PIPE_STAGES-1:0] valid_reg, valid_next;
    logic [PIPE_STAGES-1:0] load;

    always_comb begin
        load[PIPE_STAGES-1] = !valid_reg[PIPE_STAGES-1] || m_tready;
        for (int i = PIPE_STAGES - 2; i >= 0; i--) begin
            load[i] = !valid_reg[i] || load[i+1];
        end
    end

    always_comb begin
        valid_next[0] = load[0] ? s_tvalid : valid_reg[0];
        for (int i = 1; i < PIPE_STAGES; i++) begin
            if (load[i]) begin
                valid_next[i] = valid_reg[i-1];
            end else begin
                valid_next[i] = valid_reg[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign s_tready = load[0];
    assign m_tvalid = valid_reg[PIPE_STAGES-1];

    // front end
    logic [SW-1:0]        s_pipe     [Q_BITS+1];
    logic signed [RW-1:0] r_pipe     [Q_BITS+1][2];
    logic signed [RW-1:0] p_pipe     [Q_BITS+1][2];
    logic [Q_BITS-1:0]    q_pipe     [Q_BITS+1][2];
    cpn_flags_t           flags_pipe [Q_BITS+1];

    cpn_prep #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_prep (
        .aclk      (aclk),
        .en        (load[PREP_STAGES-1:0]),
        .re_in     ($signed(s_tdata[SAMPLE_WIDTH-1:0])),
        .im_in     ($signed(s_tdata[SW-1:SAMPLE_WIDTH])),
        .last_in   (s_tlast),
        .s_out     (s_pipe[0]),
        .r_out     (r_pipe[0]),
        .p_out     (p_pipe[0]),
        .flags_out (flags_pipe[0])
    );

    assign q_pipe[0][0] = '0;
    assign q_pipe[0][1] = '0;

    // one quotient bit per stage, MSB first
    for (genvar k = 0; k < Q_BITS; k++) begin : g_step
        cpn_step #(
            .SAMPLE_WIDTH (SAMPLE_WIDTH),
            .BIT          (Q_BITS - 1 - k)
        ) u_step (
            .aclk      (aclk),
            .en        (load[PREP_STAGES+k]),
            .s_in      (s_pipe[k]),
            .r_in      (r_pipe[k]),
            .p_in      (p_pipe[k]),
            .q_in      (q_pipe[k]),
            .flags_in  (flags_pipe[k]),
            .s_out     (s_pipe[k+1]),
            .r_out     (r_pipe[k+1]),
            .p_out     (p_pipe[k+1]),
            .q_out     (q_pipe[k+1]),
            .flags_out (flags_pipe[k+1])
        );
    end

    // output register
    logic signed [OUT_WIDTH-1:0] real_out, imag_out;
    logic                        zero_out;

    cpn_out u_out (
        .aclk     (aclk),
        .en       (load[PIPE_STAGES-1]),
        .q_in     (q_pipe[Q_BITS]),
        .flags_in (flags_pipe[Q_BITS]),
        .real_out (real_out),
        .imag_out (imag_out),
        .zero_out (zero_out),
        .last_out (m_tlast)
    );

    assign m_tdata = {imag_out, real_out};
    assign m_tuser = zero_out;

`ifndef SYNTHESIS
    // a zero-magnitude result carries a zero phasor
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> (m_tdata == '0))
        else $error("zero magnitude with nonzero phasor");

    // each part of the phasor stays within [-1.0, 1.0] in Q2.14
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (($signed(real_out) <= 16'sd16384) && ($signed(real_out) >= -16'sd16384)
                   && ($signed(imag_out) <= 16'sd16384) && ($signed(imag_out) >= -16'sd16384)))
        else $error("phasor part out of range");

    // input backpressure only when every stage holds a transaction
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (&valid_reg))
        else $error("input stalled with a free stage");
`endif

endmodule
`default_nettype wire

// File: sv/cpn_prep.sv
// Front end: absolute values, squares, magnitude sum and search seeds.
`default_nettype none
module cpn_prep
    import cpn_pkg::*;
#(
    parameter  int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
    localparam int SW           = 2 * SAMPLE_WIDTH,
    localparam int RW           = SW + TARGET_SHIFT + 2
) (
    input  wire logic                           aclk,
    input  wire logic [PREP_STAGES-1:0]         en,
    input  wire logic signed [SAMPLE_WIDTH-1:0] re_in,
    input  wire logic signed [SAMPLE_WIDTH-1:0] im_in,
    input  wire logic                           last_in,
    output logic [SW-1:0]                       s_out,
    output logic signed [RW-1:0]                r_out [2],
    output logic signed [RW-1:0]                p_out [2],
    output cpn_flags_t                          flags_out
);

    logic [SAMPLE_WIDTH-1:0] abs_re_reg, abs_im_reg;
    logic [SAMPLE_WIDTH-1:0] abs_re_next, abs_im_next;
    cpn_flags_t              flags_a_reg, flags_a_next;
    logic [SW-1:0]           sq_re_reg, sq_im_reg;
    cpn_flags_t              flags_b_reg;
    logic [SW-1:0]           s_sum;
    logic signed [RW-1:0]    s_ext;
    logic [SW-1:0]           s_reg;
    logic signed [RW-1:0]    r_re_reg, r_im_reg, p_reg;
    logic signed [RW-1:0]    r_re_next, r_im_next;
    cpn_flags_t              flags_c_reg, flags_c_next;

    // stage A: magnitudes, most negative value maps to 2^(W-1) unsigned
    always_comb begin
        abs_re_next         = re_in[SAMPLE_WIDTH-1] ? SAMPLE_WIDTH'(~re_in + 1'b1) : re_in;
        abs_im_next         = im_in[SAMPLE_WIDTH-1] ? SAMPLE_WIDTH'(~im_in + 1'b1) : im_in;
        flags_a_next.neg_re = re_in[SAMPLE_WIDTH-1];
        flags_a_next.neg_im = im_in[SAMPLE_WIDTH-1];
        flags_a_next.zero   = 1'b0;
        flags_a_next.last   = last_in;
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            abs_re_reg  <= abs_re_next;
            abs_im_reg  <= abs_im_next;
            flags_a_reg <= flags_a_next;
        end
    end

    // stage B: squares
    always_ff @(posedge aclk) begin
        if (en[1]) begin
            sq_re_reg   <= abs_re_reg * abs_re_reg;
            sq_im_reg   <= abs_im_reg * abs_im_reg;
            flags_b_reg <= flags_a_reg;
        end
    end

    // stage C: s = re^2 + im^2, residual seeded with u = -1
    always_comb begin
        s_sum     = sq_re_reg + sq_im_reg;
        s_ext     = $signed({{(RW - SW){1'b0}}, s_sum});
        r_re_next = $signed({{(RW - SW){1'b0}}, sq_re_reg} << TARGET_SHIFT) - s_ext;
        r_im_next = $signed({{(RW - SW){1'b0}}, sq_im_reg} << TARGET_SHIFT) - s_ext;
        flags_c_next      = flags_b_reg;
        flags_c_next.zero = (s_sum == '0);
    end

    always_ff @(posedge aclk) begin
        if (en[2]) begin
            s_reg       <= s_sum;
            r_re_reg    <= r_re_next;
            r_im_reg    <= r_im_next;
            p_reg       <= -s_ext;
            flags_c_reg <= flags_c_next;
        end
    end

    assign s_out     = s_reg;
    assign r_out[0]  = r_re_reg;
    assign r_out[1]  = r_im_reg;
    assign p_out[0]  = p_reg;
    assign p_out[1]  = p_reg;
    assign flags_out = flags_c_reg;

endmodule
`default_nettype wire

// File: sv/cpn_step.sv
// One bit of the rounded-quotient search, both lanes, one register stage.
`default_nettype none
module cpn_step
    import cpn_pkg::*;
#(
    parameter  int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
    parameter  int BIT          = 0,
    localparam int SW           = 2 * SAMPLE_WIDTH,
    localparam int RW           = SW + TARGET_SHIFT + 2
) (
    input  wire logic                  aclk,
    input  wire logic                  en,
    input  wire logic [SW-1:0]         s_in,
    input  wire logic signed [RW-1:0]  r_in [2],
    input  wire logic signed [RW-1:0]  p_in [2],
    input  wire logic [Q_BITS-1:0]     q_in [2],
    input  wire cpn_flags_t            flags_in,
    output logic [SW-1:0]              s_out,
    output logic signed [RW-1:0]       r_out [2],
    output logic signed [RW-1:0]       p_out [2],
    output logic [Q_BITS-1:0]          q_out [2],
    output cpn_flags_t                 flags_out
);

    logic signed [RW-1:0] s_ext;
    logic [SW-1:0]        s_reg;
    cpn_flags_t           flags_reg;

    assign s_ext = $signed({{(RW - SW){1'b0}}, s_in});

    always_ff @(posedge aclk) begin
        if (en) begin
            s_reg     <= s_in;
            flags_reg <= flags_in;
        end
    end

    assign s_out     = s_reg;
    assign flags_out = flags_reg;

    // R = a^2<<30 - u^2 s, P = u s, u = 2q-1; trying q + 2^BIT moves u by 2^(BIT+1)
    for (genvar l = 0; l < 2; l++) begin : g_lane
        logic signed [RW-1:0] d;
        logic                 take;
        logic signed [RW-1:0] r_reg, r_next;
        logic signed [RW-1:0] p_reg, p_next;
        logic [Q_BITS-1:0]    q_reg, q_next;

        always_comb begin
            d      = (p_in[l] <<< (BIT + 2)) + (s_ext <<< (2 * BIT + 2));
            take   = (d <= r_in[l]);
            r_next = take ? r_in[l] - d : r_in[l];
            p_next = take ? p_in[l] + (s_ext <<< (BIT + 1)) : p_in[l];
            q_next = q_in[l];
            q_next[BIT] = take;
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                r_reg <= r_next;
                p_reg <= p_next;
                q_reg <= q_next;
            end
        end

        assign r_out[l] = r_reg;
        assign p_out[l] = p_reg;
        assign q_out[l] = q_reg;
    end

endmodule
`default_nettype wire

// File: sv/cpn_out.sv
// Result stage: sign restore, zero forcing, output register.
`default_nettype none
module cpn_out
    import cpn_pkg::*;
(
    input  wire logic                        aclk,
    input  wire logic                        en,
    input  wire logic [Q_BITS-1:0]           q_in [2],
    input  wire cpn_flags_t                  flags_in,
    output logic signed [OUT_WIDTH-1:0]      real_out,
    output logic signed [OUT_WIDTH-1:0]      imag_out,
    output logic                             zero_out,
    output logic                             last_out
);

    logic [OUT_WIDTH-1:0]        q_re_ext, q_im_ext;
    logic signed [OUT_WIDTH-1:0] re_next, im_next;
    logic signed [OUT_WIDTH-1:0] re_reg, im_reg;
    logic                        zero_reg, last_reg;

    always_comb begin
        q_re_ext = {{(OUT_WIDTH - Q_BITS){1'b0}}, q_in[0]};
        q_im_ext = {{(OUT_WIDTH - Q_BITS){1'b0}}, q_in[1]};
        re_next  = flags_in.neg_re ? $signed(OUT_WIDTH'(~q_re_ext + 1'b1)) : $signed(q_re_ext);
        im_next  = flags_in.neg_im ? $signed(OUT_WIDTH'(~q_im_ext + 1'b1)) : $signed(q_im_ext);
        if (flags_in.zero) begin
            re_next = '0;
            im_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            re_reg   <= re_next;
            im_reg   <= im_next;
            zero_reg <= flags_in.zero;
            last_reg <= flags_in.last;
        end
    end

    assign real_out = re_reg;
    assign imag_out = im_reg;
    assign zero_out = zero_reg;
    assign last_out = last_reg;

endmodule
`default_nettype wire
